>>> sv/ptdm_pkg.sv
// ---------------------------------------------------------------------------
// Periodic task deadline monitor package
// Opcodes, constants and the record types shared by the monitor modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ptdm_pkg;

  localparam int unsigned MS_W       = 32;
  localparam int unsigned US_W       = 63;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  // A deadline in ms times 1000 fits in 42 bits.
  localparam int unsigned DL_US_W    = 42;
  localparam logic [DL_US_W-1:0] US_PER_MS = DL_US_W'(1000);

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_CLEAR = 2'd0;
  localparam opcode_t OP_CHECK = 2'd1;
  localparam opcode_t OP_BEGIN = 2'd2;
  localparam opcode_t OP_END   = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SET_INTERVAL = 2'd0;
  localparam cfg_idx_t REG_SET_DEADLINE = 2'd1;
  localparam cfg_idx_t REG_FB_INTERVAL  = 2'd2;
  localparam cfg_idx_t REG_FB_DEADLINE  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] set_interval_ms;
    logic [CFG_W-1:0] set_deadline_ms;
    logic [CFG_W-1:0] fallback_interval_ms;
    logic [CFG_W-1:0] fallback_deadline_ms;
  } cfg_t;

  typedef struct packed {
    opcode_t         opcode;
    logic [MS_W-1:0] now_ms;
    logic [US_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   run_counter;
    logic [MS_W-1:0]    last_dispatch_time;
    logic [DL_US_W-1:0] deadline_us;
    logic [US_W-1:0]    run_start_us;
    logic [CNT_W-1:0]   latest_duration;
    logic [CNT_W-1:0]   peak_duration;
    logic [CNT_W-1:0]   miss_counter;
  } state_t;

  typedef struct packed {
    logic             is_due;
    logic             missed;
    logic             log_miss;
    logic [CNT_W-1:0] runs_done;
    logic [CNT_W-1:0] last_run_us;
    logic [CNT_W-1:0] longest_run_us;
    logic [CNT_W-1:0] misses;
  } result_t;

endpackage

`default_nettype wire

>>> sv/ptdm_eval.sv
// ---------------------------------------------------------------------------
// Periodic task deadline monitor event evaluation
// Computes the next statistics state and the result record for one event.
// ---------------------------------------------------------------------------
`default_nettype none

module ptdm_eval (
  input  ptdm_pkg::cfg_t    cfg,
  input  ptdm_pkg::item_t   item,
  input  ptdm_pkg::state_t  state,
  output ptdm_pkg::state_t  state_next,
  output ptdm_pkg::result_t result
);

  logic [ptdm_pkg::CFG_W-1:0] interval;
  logic [ptdm_pkg::CFG_W-1:0] deadline;
  logic [ptdm_pkg::MS_W-1:0]  elapsed_ms;
  logic [ptdm_pkg::US_W-1:0]  span_us;
  logic [ptdm_pkg::CNT_W-1:0] duration;
  logic                       due;
  logic                       miss;

  always_comb begin
    interval = (cfg.set_interval_ms != '0) ? cfg.set_interval_ms : cfg.fallback_interval_ms;
    deadline = (cfg.set_deadline_ms != '0) ? cfg.set_deadline_ms : cfg.fallback_deadline_ms;
    elapsed_ms = item.now_ms - state.last_dispatch_time;

    // Runs that end before they start measure zero; long runs saturate.
    span_us = (item.now_us > state.run_start_us) ? (item.now_us - state.run_start_us) : '0;
    duration = (span_us[ptdm_pkg::US_W-1:ptdm_pkg::CNT_W] != '0) ? '1
             : span_us[ptdm_pkg::CNT_W-1:0];

    state_next = state;
    due = 1'b0;
    miss = 1'b0;

    unique case (item.opcode)
      ptdm_pkg::OP_CLEAR: begin
        state_next.run_counter        = '0;
        state_next.last_dispatch_time = '0;
        state_next.deadline_us        = '0;
        state_next.latest_duration    = '0;
        state_next.peak_duration      = '0;
        state_next.miss_counter       = '0;
      end
      ptdm_pkg::OP_CHECK: begin
        state_next.deadline_us = ptdm_pkg::DL_US_W'(deadline) * ptdm_pkg::US_PER_MS;
        if (state.run_counter == '0 || elapsed_ms >= interval) begin
          state_next.last_dispatch_time = item.now_ms;
          due = 1'b1;
        end
      end
      ptdm_pkg::OP_BEGIN: begin
        state_next.run_start_us = item.now_us;
      end
      ptdm_pkg::OP_END: begin
        state_next.run_counter     = state.run_counter + ptdm_pkg::CNT_W'(1);
        state_next.latest_duration = duration;
        if (duration > state.peak_duration) begin
          state_next.peak_duration = duration;
        end
        // A zero latched deadline disables miss detection.
        if (state.deadline_us != '0 && ptdm_pkg::DL_US_W'(duration) > state.deadline_us) begin
          state_next.miss_counter = state.miss_counter + ptdm_pkg::CNT_W'(1);
          miss = 1'b1;
        end
      end
      default: begin
        state_next = state;
      end
    endcase

    result.is_due         = due;
    result.missed         = miss;
    result.log_miss       = $onehot(state_next.miss_counter);
    result.runs_done      = state_next.run_counter;
    result.last_run_us    = state_next.latest_duration;
    result.longest_run_us = state_next.peak_duration;
    result.misses         = state_next.miss_counter;
  end

endmodule

`default_nettype wire

>>> sv/periodic_task_deadline_monitor_unit.sv
// An accepted event passes through the input register, is evaluated, and its result
// is presented from the result register.
// Throughput: one event per cycle unless the output stalls; one statistics update per event.
// A result waiting in the output register does not block the next event from
// entering the input register; only a full pipeline with the output stalled holds off input.
// Reset (rst, synchronous, active high) clears the configuration, the statistics and
// the run start time, and empties both pipeline registers.
// ---------------------------------------------------------------------------
// Periodic task deadline monitor unit
// Tracks dispatch timing, run durations and deadline misses of one periodic task.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_task_deadline_monitor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // Event channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] now_ms,
  input  wire logic [62:0] now_us,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_due,
  output logic             missed,
  output logic             log_miss,
  output logic [31:0]      runs_done,
  output logic [31:0]      last_run_us,
  output logic [31:0]      longest_run_us,
  output logic [31:0]      misses
);

  // Configuration registers.
  ptdm_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ptdm_pkg::REG_SET_INTERVAL: cfg.set_interval_ms      <= cfg_wdata;
        ptdm_pkg::REG_SET_DEADLINE: cfg.set_deadline_ms      <= cfg_wdata;
        ptdm_pkg::REG_FB_INTERVAL:  cfg.fallback_interval_ms <= cfg_wdata;
        ptdm_pkg::REG_FB_DEADLINE:  cfg.fallback_deadline_ms <= cfg_wdata;
        default:                    cfg <= cfg;
      endcase
    end
  end

  // Input register. It takes a new transfer whenever it is empty or its
  // current event is being evaluated in this cycle.
  logic            item_valid;
  ptdm_pkg::item_t item;
  logic            advance;

  // The held event is evaluated when the result register is free or drains now.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.opcode <= opcode;
      item.now_ms <= now_ms;
      item.now_us <= now_us;
    end
  end

  // Statistics state, updated once per evaluated event.
  ptdm_pkg::state_t  state;
  ptdm_pkg::state_t  state_next;
  ptdm_pkg::result_t result_next;
  ptdm_pkg::result_t result;

  ptdm_eval u_eval (
    .cfg        (cfg),
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign is_due         = result.is_due;
  assign missed         = result.missed;
  assign log_miss       = result.log_miss;
  assign runs_done      = result.runs_done;
  assign last_run_us    = result.last_run_us;
  assign longest_run_us = result.longest_run_us;
  assign misses         = result.misses;

endmodule

`default_nettype wire

>>> sv/ptdm_checker.sv
// ---------------------------------------------------------------------------
// Periodic task deadline monitor checker
// Port-level assertions on the monitor's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ptdm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_due,
  input wire logic        missed,
  input wire logic        log_miss,
  input wire logic [31:0] runs_done,
  input wire logic [31:0] last_run_us,
  input wire logic [31:0] longest_run_us,
  input wire logic [31:0] misses
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(misses) && $stable(runs_done))
    else $error("result changed while stalled");

  // The power-of-two flag follows the reported miss count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> log_miss == $onehot(misses))
    else $error("log_miss disagrees with miss count");

  // A due report and a miss come from different events.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_due && missed))
    else $error("due and missed reported together");

  // The longest run never falls below the latest one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longest_run_us >= last_run_us)
    else $error("longest run below latest run");

  // A miss always leaves a nonzero count and a nonzero run duration.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && missed |-> misses != 32'd0 && last_run_us != 32'd0)
    else $error("miss reported without count or duration");

endmodule

bind periodic_task_deadline_monitor_unit ptdm_checker u_ptdm_checker (.*);

`default_nettype wire
